/* rtl/core/hisf_pkg.sv */
`timescale 1ns / 1ps

package hisf_pkg;

    // header bytes examined before the parser gives up on the header
    localparam int HEADER_LIMIT = 511;
    localparam int HDR_CW       = $clog2(HEADER_LIMIT + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] MAX_BYTES_RESET = 16'd55296;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd15000;

    localparam logic [16:0] LEN_SAT = 17'h1FFFF;

    // register addresses (word index)
    localparam logic REG_MAX_BYTES = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    // input commands
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // result kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // finish status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_200   = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    typedef enum logic [1:0] {
        ITEM_BYTE,
        ITEM_TICK,
        ITEM_RESTART
    } hisf_kind_t;

    typedef struct packed {
        hisf_kind_t  kind;
        logic [7:0]  data;
    } hisf_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] offset;
        logic [15:0] halfword;
        logic [2:0]  status;
        logic        last;
    } hisf_result_t;

    typedef struct packed {
        logic                empty;
        logic                full;
        logic [QUEUE_AW:0]   count;
    } hisf_qstat_t;

    typedef struct packed {
        logic [15:0] max_bytes;
        logic [15:0] timeout;
    } hisf_cfg_t;

    // "200 OK"
    function automatic logic [7:0] ok_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h32;
            3'd1:    ch = 8'h30;
            3'd2:    ch = 8'h30;
            3'd3:    ch = 8'h20;
            3'd4:    ch = 8'h4F;
            3'd5:    ch = 8'h4B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "Content-Length: "
    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:  ch = 8'h43;
            4'd1:  ch = 8'h6F;
            4'd2:  ch = 8'h6E;
            4'd3:  ch = 8'h74;
            4'd4:  ch = 8'h65;
            4'd5:  ch = 8'h6E;
            4'd6:  ch = 8'h74;
            4'd7:  ch = 8'h2D;
            4'd8:  ch = 8'h4C;
            4'd9:  ch = 8'h65;
            4'd10: ch = 8'h6E;
            4'd11: ch = 8'h67;
            4'd12: ch = 8'h74;
            4'd13: ch = 8'h68;
            4'd14: ch = 8'h3A;
            4'd15: ch = 8'h20;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/core/hisf_front.sv */
`timescale 1ns / 1ps

module hisf_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    input  logic [1:0]          s_tuser,   // command
    input  hisf_pkg::hisf_qstat_t q_stat,
    output logic                q_push,
    output hisf_pkg::hisf_item_t  q_item
);
    import hisf_pkg::*;

    logic keep;

    assign s_tready = !q_stat.full;

    // unknown command codes are dropped here and never reach the queue
    always_comb begin
        keep        = 1'b1;
        q_item.data = s_tdata;
        q_item.kind = ITEM_BYTE;
        unique case (s_tuser)
            CMD_BYTE:    q_item.kind = ITEM_BYTE;
            CMD_TICK:    q_item.kind = ITEM_TICK;
            CMD_RESTART: q_item.kind = ITEM_RESTART;
            default:     keep = 1'b0;
        endcase
    end

    assign q_push = s_tvalid && s_tready && keep;

endmodule

/* rtl/core/hisf_queue.sv */
`timescale 1ns / 1ps

module hisf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hisf_pkg::hisf_item_t  wdata,
    input  logic                  pop,
    output hisf_pkg::hisf_item_t  rdata,
    output hisf_pkg::hisf_qstat_t stat
);
    import hisf_pkg::*;

    hisf_item_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rdata      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/hisf_back.sv */
`timescale 1ns / 1ps

module hisf_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hisf_pkg::hisf_cfg_t    cfg,
    input  hisf_pkg::hisf_qstat_t  q_stat,
    input  hisf_pkg::hisf_item_t   q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hisf_pkg::hisf_result_t out_res
);
    import hisf_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [1:0] LS_MATCH = 2'd0;
    localparam logic [1:0] LS_SPACE = 2'd1;
    localparam logic [1:0] LS_DIGIT = 2'd2;
    localparam logic [1:0] LS_DONE  = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    logic [1:0]        phase_reg, phase_next;
    logic [HDR_CW-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [2:0]        end_match_reg, end_match_next;
    logic [2:0]        ok_match_reg, ok_match_next;
    logic              ok_seen_reg, ok_seen_next;
    logic [4:0]        len_match_reg, len_match_next;
    logic [1:0]        len_step_reg, len_step_next;
    logic              len_neg_reg, len_neg_next;
    logic [16:0]       len_val_reg, len_val_next;
    logic [15:0]       rcv_cnt_reg, rcv_cnt_next;
    logic [7:0]        low_byte_reg, low_byte_next;
    logic              have_low_reg, have_low_next;
    logic [31:0]       first_word_reg, first_word_next;
    logic [15:0]       idle_reg, idle_next;

    logic              out_valid_reg, pend_valid_reg;
    hisf_result_t      out_res_reg, pend_res_reg;

    hisf_result_t      r0, r1;
    logic [1:0]        n_res;
    logic [7:0]        c;
    logic              is_digit, is_space, img_ok;
    logic [20:0]       len_prod;
    logic              out_free;

    assign c        = q_item.data;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    assign len_prod = {4'd0, len_val_reg} * 21'd10 + {17'd0, c[3:0]};

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = !q_stat.empty && !pend_valid_reg && out_free;

    always_comb begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        end_match_next  = end_match_reg;
        ok_match_next   = ok_match_reg;
        ok_seen_next    = ok_seen_reg;
        len_match_next  = len_match_reg;
        len_step_next   = len_step_reg;
        len_neg_next    = len_neg_reg;
        len_val_next    = len_val_reg;
        rcv_cnt_next    = rcv_cnt_reg;
        low_byte_next   = low_byte_reg;
        have_low_next   = have_low_reg;
        first_word_next = first_word_reg;
        idle_next       = idle_reg;
        r0              = '0;
        r1              = '0;
        n_res           = 2'd0;
        img_ok          = 1'b0;

        if (q_pop) begin
            unique case (q_item.kind)
                ITEM_RESTART: begin
                    phase_next      = PH_HEADER;
                    hdr_cnt_next    = '0;
                    end_match_next  = '0;
                    ok_match_next   = '0;
                    ok_seen_next    = 1'b0;
                    len_match_next  = '0;
                    len_step_next   = LS_MATCH;
                    len_neg_next    = 1'b0;
                    len_val_next    = '0;
                    rcv_cnt_next    = '0;
                    low_byte_next   = '0;
                    have_low_next   = 1'b0;
                    first_word_next = 32'hFFFF_FFFF;
                    idle_next       = '0;
                end
                ITEM_TICK: begin
                    if (phase_reg != PH_DONE) begin
                        if (idle_reg != 16'hFFFF) begin
                            idle_next = idle_reg + 16'd1;
                        end
                        if (idle_next >= cfg.timeout) begin
                            r0.kind    = KIND_DONE;
                            r0.status  = ST_TIMEOUT;
                            n_res      = 2'd1;
                            phase_next = PH_DONE;
                        end
                    end
                end
                ITEM_BYTE: begin
                    if (phase_reg == PH_HEADER) begin
                        idle_next = '0;
                        if (hdr_cnt_reg < HDR_CW'(HEADER_LIMIT)) begin
                            hdr_cnt_next = hdr_cnt_reg + 1'b1;

                            // status line match
                            if (c == ok_char(ok_match_reg)) begin
                                ok_match_next = ok_match_reg + 3'd1;
                            end else begin
                                ok_match_next = (c == CH_TWO) ? 3'd1 : 3'd0;
                            end
                            if (ok_match_next == 3'd6) begin
                                ok_seen_next  = 1'b1;
                                ok_match_next = 3'd0;
                            end

                            // length field: match key, skip space, sign, digits
                            unique case (len_step_reg)
                                LS_MATCH: begin
                                    if (c == cl_char(len_match_reg[3:0])) begin
                                        len_match_next = len_match_reg + 5'd1;
                                    end else begin
                                        len_match_next = (c == CH_C) ? 5'd1 : 5'd0;
                                    end
                                    if (len_match_next == 5'd16) begin
                                        len_step_next = LS_SPACE;
                                    end
                                end
                                LS_SPACE: begin
                                    priority if (is_space) begin
                                        len_step_next = LS_SPACE;
                                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                                        len_neg_next  = (c == CH_MINUS);
                                        len_step_next = LS_DIGIT;
                                    end else if (is_digit) begin
                                        len_val_next  = {13'd0, c[3:0]};
                                        len_step_next = LS_DIGIT;
                                    end else begin
                                        len_step_next = LS_DONE;
                                    end
                                end
                                LS_DIGIT: begin
                                    if (is_digit) begin
                                        len_val_next = (len_prod > {4'd0, LEN_SAT}) ?
                                                       LEN_SAT : len_prod[16:0];
                                    end else begin
                                        len_step_next = LS_DONE;
                                    end
                                end
                                LS_DONE: begin
                                    len_step_next = LS_DONE;
                                end
                            endcase

                            // blank line search
                            if (c == (end_match_reg[0] ? CH_LF : CH_CR)) begin
                                end_match_next = end_match_reg + 3'd1;
                            end else begin
                                end_match_next = (c == CH_CR) ? 3'd1 : 3'd0;
                            end

                            if (end_match_next == 3'd4) begin
                                priority if (!ok_seen_next) begin
                                    r0.kind    = KIND_DONE;
                                    r0.status  = ST_NO_200;
                                    n_res      = 2'd1;
                                    phase_next = PH_DONE;
                                end else if (len_neg_next || len_val_next == '0 ||
                                             len_val_next > {1'b0, cfg.max_bytes}) begin
                                    r0.kind    = KIND_DONE;
                                    r0.status  = ST_BAD_LEN;
                                    n_res      = 2'd1;
                                    phase_next = PH_DONE;
                                end else begin
                                    phase_next = PH_BODY;
                                end
                            end
                        end
                    end else if (phase_reg == PH_BODY) begin
                        idle_next = '0;
                        if (rcv_cnt_reg < 16'd4) begin
                            first_word_next[{rcv_cnt_reg[1:0], 3'b000} +: 8] = c;
                        end
                        if (!have_low_reg) begin
                            low_byte_next = c;
                            have_low_next = 1'b1;
                        end else begin
                            r0.kind     = KIND_WRITE;
                            r0.offset   = rcv_cnt_reg - 16'd1;
                            r0.halfword = {c, low_byte_reg};
                            n_res       = 2'd1;
                            have_low_next = 1'b0;
                        end
                        rcv_cnt_next = rcv_cnt_reg + 16'd1;

                        if ({1'b0, rcv_cnt_next} >= len_val_reg) begin
                            img_ok = (first_word_next != 32'hFFFF_FFFF) &&
                                     first_word_next[29];
                            if (have_low_next) begin
                                // odd last byte, padded as erased flash
                                r0.kind     = KIND_WRITE;
                                r0.offset   = rcv_cnt_next - 16'd1;
                                r0.halfword = {8'hFF, low_byte_next};
                                r1.kind     = KIND_DONE;
                                r1.status   = img_ok ? ST_OK : ST_INVALID;
                                n_res       = 2'd2;
                            end else if (n_res == 2'd1) begin
                                r1.kind   = KIND_DONE;
                                r1.status = img_ok ? ST_OK : ST_INVALID;
                                n_res     = 2'd2;
                            end else begin
                                r0.kind   = KIND_DONE;
                                r0.status = img_ok ? ST_OK : ST_INVALID;
                                n_res     = 2'd1;
                            end
                            have_low_next = 1'b0;
                            phase_next    = PH_DONE;
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (n_res == 2'd1) begin
            r0.last = 1'b1;
        end
        if (n_res == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            end_match_reg  <= '0;
            ok_match_reg   <= '0;
            ok_seen_reg    <= 1'b0;
            len_match_reg  <= '0;
            len_step_reg   <= LS_MATCH;
            len_neg_reg    <= 1'b0;
            len_val_reg    <= '0;
            rcv_cnt_reg    <= '0;
            low_byte_reg   <= '0;
            have_low_reg   <= 1'b0;
            first_word_reg <= 32'hFFFF_FFFF;
            idle_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            end_match_reg  <= end_match_next;
            ok_match_reg   <= ok_match_next;
            ok_seen_reg    <= ok_seen_next;
            len_match_reg  <= len_match_next;
            len_step_reg   <= len_step_next;
            len_neg_reg    <= len_neg_next;
            len_val_reg    <= len_val_next;
            rcv_cnt_reg    <= rcv_cnt_next;
            low_byte_reg   <= low_byte_next;
            have_low_reg   <= have_low_next;
            first_word_reg <= first_word_next;
            idle_reg       <= idle_next;
            if (pend_valid_reg && out_free) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (q_pop) begin
                out_valid_reg  <= (n_res != 2'd0);
                pend_valid_reg <= (n_res == 2'd2);
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_valid_reg && out_free) begin
            out_res_reg <= pend_res_reg;
        end else if (q_pop) begin
            out_res_reg  <= r0;
            pend_res_reg <= r1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

/* rtl/core/http_image_stream_to_flash_writes.sv */
`timescale 1ns / 1ps

// Turns a received HTTP response into halfword flash writes. Each input request
// carries a command in s_tuser (received byte, millisecond tick, restart) and
// the byte in s_tdata. The header is scanned for the status "200 OK", the
// Content-Length value and the blank line; body bytes then leave as halfword
// writes (low byte first, odd tail padded with 0xFF) followed by one finished
// request carrying the status. After finishing, bytes and ticks are dropped
// until a restart. Rate: one input request per clock while the queue is not
// full; the front end classifies and pushes into a 4-entry queue, the back end
// executes one queued request per clock when its output register is free. A
// request with two results (odd final byte plus finish, or last pair plus finish)
// stalls the back end until the second is staged. No clearing pass after reset.

module http_image_stream_to_flash_writes (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] offset, [31:16] halfword, [34:32] status
    output logic [0:0]  m_tuser,   // [0] kind
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hisf_pkg::*;

    logic [15:0]  max_bytes_reg, timeout_reg;
    hisf_cfg_t    cfg;
    hisf_qstat_t  q_stat;
    hisf_item_t   push_item, pop_item;
    logic         q_push, q_pop;
    hisf_result_t res;
    logic         cfg_wr;

    // registers at byte address 0 and 4; low address bits are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {16'd0, (paddr[2] == REG_TIMEOUT) ? timeout_reg : max_bytes_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
            timeout_reg   <= TIMEOUT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAX_BYTES) begin
                max_bytes_reg <= pwdata[15:0];
            end else begin
                timeout_reg <= pwdata[15:0];
            end
        end
    end

    assign cfg.max_bytes = max_bytes_reg;
    assign cfg.timeout   = timeout_reg;

    // front: classify and enqueue
    hisf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    hisf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (push_item),
        .pop     (q_pop),
        .rdata   (pop_item),
        .stat    (q_stat)
    );

    // back: parser state, write pairing, output staging
    hisf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {5'd0, res.status, res.halfword, res.offset};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // a finished request always closes the results of its input
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_DONE) |-> m_tlast)
        else $error("finish result without last");

    // writes carry no status
    a_write_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_WRITE) |-> (m_tdata[34:32] == ST_OK))
        else $error("write result with nonzero status");

    // finish status stays within the defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == KIND_DONE) |-> (m_tdata[34:32] <= ST_INVALID))
        else $error("finish status out of range");

    // queue occupancy bounded
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue overflow");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for http_image_stream_to_flash_writes.
// Input requests are HTTP response bytes, ms ticks and restarts; every accepted
// request is run through a local download model that queues the flash writes
// and the finish request it should cause. Results are compared in order.

module tb;
    import hisf_pkg::*;

    localparam logic [1:0] CMD_UNDEFINED = 2'd3;     // block must drop it
    localparam logic [2:0] NO_FINISH     = 3'd7;     // probe row yields nothing
    localparam logic [7:0] CR            = 8'h0D;
    localparam logic [7:0] LF            = 8'h0A;
    localparam logic [47:0]  OK_TEXT     = "200 OK";
    localparam logic [127:0] CL_TEXT     = "Content-Length: ";
    localparam logic [47:0]  WS_SET      = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    localparam int DRAIN_CYCLES   = 24;              // queue depth plus back end
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {DL_HEADER, DL_BODY, DL_DONE} dl_phase_t;
    typedef enum logic [1:0] {LEN_SEEK, LEN_SPACE, LEN_DIGITS, LEN_DONE} len_step_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic [2:0] want;    // finish status, or NO_FINISH
    } probe_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic [1:0]  s_tuser;    // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [15:0] offset, [31:16] halfword, [34:32] status
    logic [0:0]  m_tuser;    // [0] kind
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    http_image_stream_to_flash_writes dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Download model: register copies and parser state
    // ---------------------------------------------------------------------
    logic [15:0]  cfg_max_len;
    logic [15:0]  cfg_idle_limit;

    dl_phase_t    dl_phase;
    int           hdr_seen;
    int           crlf_run;
    int           ok_run;
    bit           ok_found;
    int           cl_run;
    len_step_t    len_step;
    bit           len_neg;
    logic [16:0]  len_val;
    logic [16:0]  body_count;
    logic [7:0]   held_byte;
    bit           byte_held;
    logic [31:0]  image_word;
    logic [15:0]  idle_run;

    hisf_result_t step_ops[$];        // results of the request just accepted
    hisf_result_t flash_ops_due[$];   // results the block still owes us
    probe_row_t   probe_rows[$];
    logic [7:0]   resp_q[$];

    int mismatches   = 0;
    int live_items   = 0;             // requests the block did not drop
    int idle_pct     = 29;
    int tick_pct     = 5;
    int stall_cycles = 0;

    function automatic hisf_result_t make_op(input logic kind, input logic [15:0] off,
                                             input logic [15:0] hw, input logic [2:0] st);
        hisf_result_t op;
        op.kind     = kind;
        op.offset   = off;
        op.halfword = hw;
        op.status   = st;
        op.last     = 1'b0;
        return op;
    endfunction

    function automatic void clear_download();
        dl_phase   = DL_HEADER;
        hdr_seen   = 0;
        crlf_run   = 0;
        ok_run     = 0;
        ok_found   = 1'b0;
        cl_run     = 0;
        len_step   = LEN_SEEK;
        len_neg    = 1'b0;
        len_val    = '0;
        body_count = '0;
        held_byte  = '0;
        byte_held  = 1'b0;
        image_word = '1;
        idle_run   = '0;
    endfunction

    function automatic void end_download(input logic [2:0] st);
        step_ops.push_back(make_op(KIND_DONE, 16'd0, 16'd0, st));
        dl_phase = DL_DONE;
    endfunction

    function automatic void header_byte(input logic [7:0] c);
        int v;
        logic [7:0] eol;
        if (hdr_seen >= HEADER_LIMIT) begin
            return;   // past the scan window: byte only resets the idle count
        end
        hdr_seen++;

        if (ok_run < 6 && c == OK_TEXT[8*(5-ok_run) +: 8]) begin
            ok_run++;
        end else begin
            ok_run = (c == "2") ? 1 : 0;
        end
        if (ok_run == 6) begin
            ok_found = 1'b1;
            ok_run   = 0;
        end

        // atoi-style length parse after the first "Content-Length: "
        case (len_step)
            LEN_SEEK: begin
                if (cl_run < 16 && c == CL_TEXT[8*(15-cl_run) +: 8]) begin
                    cl_run++;
                end else begin
                    cl_run = (c == "C") ? 1 : 0;
                end
                if (cl_run == 16) begin
                    len_step = LEN_SPACE;
                end
            end
            LEN_SPACE: begin
                if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
                    if (c == "+" || c == "-") begin
                        len_neg  = (c == "-");
                        len_step = LEN_DIGITS;
                    end else if (c >= "0" && c <= "9") begin
                        len_val  = 17'(c - "0");
                        len_step = LEN_DIGITS;
                    end else begin
                        len_step = LEN_DONE;
                    end
                end
            end
            LEN_DIGITS: begin
                if (c >= "0" && c <= "9") begin
                    v = int'(len_val) * 10 + int'(c - "0");
                    len_val = (v > int'(LEN_SAT)) ? LEN_SAT : 17'(v);
                end else begin
                    len_step = LEN_DONE;
                end
            end
            default: begin
            end
        endcase

        eol = crlf_run[0] ? LF : CR;
        if (c == eol) begin
            crlf_run++;
        end else begin
            crlf_run = (c == CR) ? 1 : 0;
        end
        if (crlf_run < 4) begin
            return;
        end

        // blank line: status check first, then the length
        if (!ok_found) begin
            end_download(ST_NO_200);
        end else if (len_neg || len_val == 0 || len_val > {1'b0, cfg_max_len}) begin
            end_download(ST_BAD_LEN);
        end else begin
            dl_phase = DL_BODY;
        end
    endfunction

    function automatic void body_byte(input logic [7:0] c);
        int r;
        logic [15:0] off;
        r = int'(body_count);
        if (r < 4) begin
            image_word[8*r +: 8] = c;
        end
        if (!byte_held) begin
            held_byte = c;
            byte_held = 1'b1;
        end else begin
            off = 16'(r - 1);
            step_ops.push_back(make_op(KIND_WRITE, off, {c, held_byte}, ST_OK));
            byte_held = 1'b0;
        end
        body_count = 17'(r + 1);
        if (body_count >= len_val) begin
            if (byte_held) begin
                off = 16'(body_count - 17'd1);
                step_ops.push_back(make_op(KIND_WRITE, off, {8'hFF, held_byte}, ST_OK));
                byte_held = 1'b0;
            end
            // erased flash reads all ones; image needs bit 29 of the first word
            end_download((image_word != '1 && image_word[29]) ? ST_OK : ST_INVALID);
        end
    endfunction

    // Runs one accepted request; fills step_ops, returns 0 if the block drops it.
    function automatic bit advance_download(input logic [1:0] cmd, input logic [7:0] c);
        hisf_result_t tail;
        step_ops.delete();
        if (cmd == CMD_RESTART) begin
            clear_download();
            return 1'b1;
        end
        if (dl_phase == DL_DONE || cmd == CMD_UNDEFINED) begin
            return 1'b0;
        end
        if (cmd == CMD_BYTE) begin
            idle_run = '0;
            if (dl_phase == DL_HEADER) begin
                header_byte(c);
            end else begin
                body_byte(c);
            end
        end else begin
            if (idle_run != 16'hFFFF) begin
                idle_run++;
            end
            if (idle_run >= cfg_idle_limit) begin
                end_download(ST_TIMEOUT);
            end
        end
        if (step_ops.size() != 0) begin
            tail = step_ops.pop_back();
            tail.last = 1'b1;
            step_ops.push_back(tail);
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // One input request: random gap, then hold until the handshake edge.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] data);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (advance_download(cmd, data)) begin
            live_items++;
        end
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
        send_request(cmd, data);
        foreach (step_ops[i]) begin
            flash_ops_due.push_back(step_ops[i]);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_BYTES) begin
            cfg_max_len = value;
        end else begin
            cfg_idle_limit = value;
        end
    endtask

    // Quiesce before a register write: all results in, then pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (flash_ops_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_probe(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [2:0] want);
        probe_row_t row;
        row.cmd  = cmd;
        row.data = data;
        row.want = want;
        probe_rows.push_back(row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            resp_q.push_back(s[i]);
        end
    endtask

    task automatic add_crlf();
        resp_q.push_back(CR);
        resp_q.push_back(LF);
    endtask

    task automatic add_line(input string s);
        add_text(s);
        add_crlf();
    endtask

    // Feeds resp_q after a restart, with ticks sprinkled in.
    task automatic play_response();
        send_item(CMD_RESTART, 8'($urandom));
        foreach (resp_q[i]) begin
            if ($urandom_range(99) < tick_pct) begin
                send_item(CMD_TICK, 8'($urandom));
            end
            send_item(CMD_BYTE, resp_q[i]);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(16, 4)) begin
            send_item(2'($urandom_range(3)), 8'($urandom));
        end
    endtask

    // Mostly well-formed responses; a share has broken status, length or body.
    task automatic send_download();
        int len;
        int nbody;
        int pick;
        int img;
        bit cut;
        logic [7:0] b;
        resp_q.delete();

        pick = $urandom_range(99);
        if (pick < 84) begin
            add_line("HTTP/1.1 200 OK");
        end else if (pick < 92) begin
            add_line("HTTP/1.1 404 Not Found");
        end else begin
            add_line("HTTP/1.1 200 Ok");
        end
        if ($urandom_range(3) == 0) begin
            add_line("Content-Type: app");   // shares a prefix with the length key
        end

        pick = $urandom_range(99);
        if (pick < 70) begin
            len = $urandom_range(24, 1);
        end else if (pick < 80) begin
            len = $urandom_range(64, 25);
        end else if (pick < 90) begin
            len = (cfg_max_len <= 64) ? int'(cfg_max_len) : $urandom_range(8, 1);
        end else begin
            len = cfg_max_len + 1;           // one past the limit
        end

        pick = $urandom_range(99);
        if (pick >= 4) begin
            add_text("Content-Length: ");
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(3, 1)) begin
                    resp_q.push_back(WS_SET[8*$urandom_range(5) +: 8]);
                end
            end
            if (pick < 8) begin
                add_text("-0");
            end else if (pick < 12) begin
                add_text("0");
            end else if (pick < 15) begin
                add_text("1234567");         // saturates
            end else if (pick < 18) begin
                add_text("x5");
            end else begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    add_text("+");
                end else if (pick < 13) begin
                    add_text("-");
                end
                if ($urandom_range(9) == 0) begin
                    add_text("00");
                end
                add_text($sformatf("%0d", len));
            end
            if ($urandom_range(9) == 0) begin
                add_text(" ;q");
            end
            add_crlf();
        end
        if ($urandom_range(4) == 0) begin
            add_line("Connection: close");
        end
        add_crlf();

        // body, sometimes cut short so only a timeout can end it
        cut   = ($urandom_range(99) < 8) && len > 0;
        nbody = (len > 70) ? 3 : len;
        if (cut && nbody > 0) begin
            nbody = $urandom_range(nbody - 1);
        end
        img = $urandom_range(9);
        for (int i = 0; i < nbody; i++) begin
            b = 8'($urandom);
            if (i < 4 && img == 0) begin
                b = 8'hFF;
            end else if (i == 3) begin
                b[5] = (img != 1);
            end
            resp_q.push_back(b);
        end
        play_response();
        if (cut) begin
            repeat ((cfg_idle_limit <= 64) ? int'(cfg_idle_limit) + 1 : 3) begin
                send_item(CMD_TICK, 8'($urandom));
            end
        end
    endtask

    task automatic run_downloads(input int quota);
        int target;
        target = live_items + quota;
        while (live_items < target) begin
            if ($urandom_range(99) < 10) begin
                send_noise();
            end else begin
                send_download();
            end
        end
    endtask

    // Header longer than the scan window: blank line arrives too late, so
    // only the idle timeout can end the download.
    task automatic send_long_header();
        resp_q.delete();
        add_line("HTTP/1.1 200 OK");
        add_line("Content-Length: 4");
        while (resp_q.size() < HEADER_LIMIT + 4) begin
            resp_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
        end
        add_crlf();
        add_crlf();
        add_text("abcd");
        play_response();
        repeat (int'(cfg_idle_limit) + 1) begin
            send_item(CMD_TICK, 8'($urandom));
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: random back-pressure, in-order compare
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        hisf_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (flash_ops_due.size() == 0) begin
                $display("%0t: unexpected result, got kind %0d offset 0x%0h data 0x%0h",
                         $time, m_tuser[0], m_tdata[15:0], m_tdata[31:16]);
                mismatches++;
            end else begin
                want = flash_ops_due.pop_front();
                check_field("kind", want.kind, m_tuser[0]);
                check_field("offset", want.offset, m_tdata[15:0]);
                check_field("halfword", want.halfword, m_tdata[31:16]);
                check_field("status", want.status, m_tdata[34:32]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // Watchdog: cycles in a row with no request moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_max_len    = MAX_BYTES_RESET;
        cfg_idle_limit = TIMEOUT_RESET;
        clear_download();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Probe table, timeout of 3 ticks: idle counting, dropped commands,
        // finished state, restart, and both header rejection verdicts.
        write_reg(REG_TIMEOUT, 16'd3);
        add_probe(CMD_TICK,      8'h00, NO_FINISH);
        add_probe(CMD_UNDEFINED, 8'hFF, NO_FINISH);   // dropped, no idle count
        add_probe(CMD_TICK,      8'h5A, NO_FINISH);
        add_probe(CMD_BYTE,      8'h00, NO_FINISH);   // byte clears idle count
        add_probe(CMD_TICK,      8'hA5, NO_FINISH);
        add_probe(CMD_TICK,      8'h00, NO_FINISH);
        add_probe(CMD_TICK,      8'h00, ST_TIMEOUT);
        add_probe(CMD_BYTE,      8'hFF, NO_FINISH);   // finished: dropped
        add_probe(CMD_TICK,      8'h00, NO_FINISH);
        add_probe(CMD_RESTART,   8'hFF, NO_FINISH);
        add_probe(CMD_BYTE,      CR,    NO_FINISH);
        add_probe(CMD_BYTE,      LF,    NO_FINISH);
        add_probe(CMD_BYTE,      CR,    NO_FINISH);
        add_probe(CMD_BYTE,      LF,    ST_NO_200);   // blank line, no status
        add_probe(CMD_RESTART,   8'h00, NO_FINISH);
        for (int i = 0; i < 6; i++) begin
            add_probe(CMD_BYTE, OK_TEXT[8*(5-i) +: 8], NO_FINISH);
        end
        add_probe(CMD_BYTE,      CR,    NO_FINISH);
        add_probe(CMD_BYTE,      LF,    NO_FINISH);
        add_probe(CMD_BYTE,      CR,    NO_FINISH);
        add_probe(CMD_BYTE,      LF,    ST_BAD_LEN);  // status ok, no length
        foreach (probe_rows[i]) begin
            send_request(probe_rows[i].cmd, probe_rows[i].data);
            if (probe_rows[i].want != NO_FINISH) begin
                flash_ops_due.push_back(make_op(KIND_DONE, 16'd0, 16'd0, probe_rows[i].want));
                flash_ops_due[flash_ops_due.size()-1].last = 1'b1;
            end
        end

        // widest length limit, short idle timeout
        settle();
        write_reg(REG_MAX_BYTES, 16'hFFFF);
        write_reg(REG_TIMEOUT, 16'd20);
        run_downloads(240);

        // narrowest settings: one-byte images, any tick ends the download
        settle();
        write_reg(REG_MAX_BYTES, 16'd1);
        write_reg(REG_TIMEOUT, 16'd1);
        tick_pct = 2;
        run_downloads(110);

        // no idling on either side, timeout effectively never
        settle();
        write_reg(REG_MAX_BYTES, 16'd40);
        write_reg(REG_TIMEOUT, 16'hFFFF);
        idle_pct = 0;
        tick_pct = 5;
        run_downloads(220);
        idle_pct = 29;

        // zero timeout: first tick ends it
        settle();
        write_reg(REG_MAX_BYTES, 16'd30);
        write_reg(REG_TIMEOUT, 16'd0);
        tick_pct = 2;
        run_downloads(110);

        // header overflow, then ordinary traffic
        settle();
        write_reg(REG_MAX_BYTES, 16'd200);
        write_reg(REG_TIMEOUT, 16'd12);
        tick_pct = 5;
        send_long_header();
        run_downloads(130);

        // back to power-on values
        settle();
        write_reg(REG_MAX_BYTES, MAX_BYTES_RESET);
        write_reg(REG_TIMEOUT, TIMEOUT_RESET);
        run_downloads(180);

        settle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
